@@ sv/swm_pkg.sv @@
// Shared constants, types and the window size clamp function of the sliding window median filter.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 32;
    localparam int CFG_W        = 7;
    localparam int CNT_W        = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W        = $clog2(WINDOW_MAX);
    localparam int WIN_RESET    = 3;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic [CNT_W-1:0]               t_cnt;
    typedef logic [IDX_W-1:0]               t_idx;
    typedef logic [CFG_W-1:0]               t_cfg;
    typedef logic [WINDOW_MAX-1:0]          t_win_vec;

    // One entry of the sorted window: the sample and how many words ago it arrived.
    typedef struct packed {
        t_sample value;
        t_idx    age;
    } t_cell;

    // Control from the top level to the sorted window.
    typedef struct packed {
        logic load;
        logic full;
        t_cnt fill;
        t_idx win_last;
    } t_swm_ctrl;

    // A window size of zero means one; sizes beyond the storage saturate.
    function automatic t_cnt clamp_window(input t_cfg value);
        t_cnt result;
        if (value == '0) begin
            result = t_cnt'(1);
        end else if (CNT_W'(value) > t_cnt'(WINDOW_MAX)) begin
            result = t_cnt'(WINDOW_MAX);
        end else begin
            result = CNT_W'(value);
        end
        return result;
    endfunction

endpackage

`default_nettype wire

@@ sv/swm_sample_if.sv @@
// Valid/ready channel that carries one input sample word.
`timescale 1ns / 1ps
`default_nettype none

interface swm_sample_if;
    import swm_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

@@ sv/swm_median_if.sv @@
// Valid/ready channel that carries one median result word.
`timescale 1ns / 1ps
`default_nettype none

interface swm_median_if;
    import swm_pkg::*;

    logic    valid;
    logic    ready;
    t_sample median;

    modport source (output valid, output median, input ready);
    modport sink (input valid, input median, output ready);
endinterface

`default_nettype wire

@@ sv/sliding_window_median.sv @@
// Sliding window lower median filter: top level with fill control and output register.
// Throughput: one word per cycle, but input ready drops while a pending median waits on a
// blocked output register; the sorted cells update when a word is accepted, and the median
// is then picked from them into the output register once that register is free.
// Reset: synchronous active low; window size returns to 3 and the window starts empty.
// A window size write also empties the window; no new result comes until it refills.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire swm_pkg::t_cfg i_cfg_data,
    swm_sample_if.sink         i_sample_if,
    swm_median_if.source       o_median_if
);
    import swm_pkg::*;

    t_cnt      r_win;
    t_cnt      r_fill;
    logic      r_pend;
    logic      r_out_valid;
    t_sample   r_out_median;
    t_sample   cell_median;
    t_swm_ctrl ctrl;
    logic      acc;
    logic      out_free;
    logic      full;
    logic      emit;
    t_idx      mid_idx;

    assign out_free = !r_out_valid || o_median_if.ready;
    // A pending median sits in the cells, so they may change only when it moves out.
    assign i_sample_if.ready = !r_pend || out_free;
    assign acc  = i_sample_if.valid && i_sample_if.ready;
    assign full = (r_fill == r_win);
    assign emit = acc && (full || (r_fill + t_cnt'(1) == r_win));
    assign mid_idx = IDX_W'((r_win - t_cnt'(1)) >> 1);

    always_comb begin
        ctrl.load     = acc;
        ctrl.full     = full;
        ctrl.fill     = r_fill;
        ctrl.win_last = IDX_W'(r_win - t_cnt'(1));
    end

    swm_sorted_window u_sorted (
        .i_clk     (i_clk),
        .i_ctrl    (ctrl),
        .i_sample  (i_sample_if.sample),
        .i_mid_idx (mid_idx),
        .o_median  (cell_median)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= t_cnt'(WIN_RESET);
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_win  <= clamp_window(i_cfg_data);
                r_fill <= '0;
            end else if (acc && !full) begin
                r_fill <= r_fill + t_cnt'(1);
            end
            if (out_free) begin
                r_out_valid <= r_pend;
            end
            r_pend <= emit || (r_pend && !out_free);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && out_free) begin
            r_out_median <= cell_median;
        end
    end

    assign o_median_if.valid  = r_out_valid;
    assign o_median_if.median = r_out_median;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_win)
        else $error("fill count exceeds window size");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_sample_if.ready |-> (r_pend && r_out_valid && !o_median_if.ready))
        else $error("input stalled without a blocked result");

    a_full_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && full) |=> r_pend)
        else $error("word into a full window gave no result");

endmodule

`default_nettype wire

@@ sv/swm_sorted_window.sv @@
// Row of sorted cells with parallel remove-oldest and insert-newest update.
`timescale 1ns / 1ps
`default_nettype none

module swm_sorted_window (
    input  wire logic              i_clk,
    input  wire swm_pkg::t_swm_ctrl i_ctrl,
    input  wire swm_pkg::t_sample  i_sample,
    input  wire swm_pkg::t_idx     i_mid_idx,
    output swm_pkg::t_sample       o_median
);
    import swm_pkg::*;

    localparam t_win_vec ALL_ONES = '1;

    t_cell    r_cell [WINDOW_MAX];
    t_cell    n_cell [WINDOW_MAX];
    t_cell    sh_cell [WINDOW_MAX];
    t_win_vec le;
    t_win_vec rm_flag;
    t_win_vec rm_le;
    t_win_vec le_sh;
    t_cnt     fill_after_rm;

    always_comb begin
        fill_after_rm = i_ctrl.full ? i_ctrl.fill - t_cnt'(1) : i_ctrl.fill;

        // Per cell: does it sort at or below the new word, and is it the oldest one.
        for (int j = 0; j < WINDOW_MAX; j++) begin
            le[j]      = (r_cell[j].value <= i_sample);
            rm_flag[j] = i_ctrl.full && (t_cnt'(j) < i_ctrl.fill) &&
                         (r_cell[j].age == i_ctrl.win_last);
        end

        // Cells at or above the removed one close the gap by taking their upper neighbor.
        for (int j = 0; j < WINDOW_MAX; j++) begin
            rm_le[j] = |(rm_flag & (ALL_ONES >> (WINDOW_MAX - 1 - j)));
        end

        for (int j = 0; j < WINDOW_MAX; j++) begin
            int nxt;
            nxt = (j < WINDOW_MAX - 1) ? j + 1 : j;
            if (rm_le[j]) begin
                sh_cell[j] = r_cell[nxt];
                le_sh[j]   = le[nxt] && (t_cnt'(j) < fill_after_rm);
            end else begin
                sh_cell[j] = r_cell[j];
                le_sh[j]   = le[j] && (t_cnt'(j) < fill_after_rm);
            end
        end

        // The new word lands after every entry that is not greater than it.
        for (int j = 0; j < WINDOW_MAX; j++) begin
            int prv;
            prv = (j > 0) ? j - 1 : 0;
            if (le_sh[j]) begin
                n_cell[j].value = sh_cell[j].value;
                n_cell[j].age   = sh_cell[j].age + t_idx'(1);
            end else if (j == 0 || le_sh[prv]) begin
                n_cell[j].value = i_sample;
                n_cell[j].age   = '0;
            end else begin
                n_cell[j].value = sh_cell[prv].value;
                n_cell[j].age   = sh_cell[prv].age + t_idx'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            for (int j = 0; j < WINDOW_MAX; j++) begin
                r_cell[j] <= n_cell[j];
            end
        end
    end

    assign o_median = r_cell[i_mid_idx].value;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Testbench for the sliding window median filter: directed table, random windows, self-check.
`timescale 1ns / 1ps

module tb_top;
    import swm_pkg::*;

    localparam int RAND_WORDS = 650;
    localparam int DRAIN      = 4;
    localparam int LIMIT      = 400000;

    typedef enum logic {ROW_CFG, ROW_WORD} t_row_kind;

    typedef struct packed {
        t_row_kind kind;
        t_cfg      cfg;
        t_sample   word;
        logic      typed;
        t_sample   median;
    } t_row;

    localparam int NPLAN = 23;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    t_cfg i_cfg_data;
    logic no_stall = 1'b0;

    swm_sample_if smp_if ();
    swm_median_if med_if ();

    sliding_window_median u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_sample_if (smp_if),
        .o_median_if (med_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Window contents kept twice, in arrival order and sorted, plus the medians still owed.
    t_sample win_arrival [$];
    t_sample win_sorted [$];
    t_sample median_q [$];
    int      win_size;
    t_sample last_word;

    int errors       = 0;
    int cycles       = 0;
    int words_sent   = 0;
    int medians_seen = 0;
    int windows_set  = 0;

    // Directed rows. The window is 3 out of reset, then sizes 1, 2, 3 and 4.
    t_row plan [NPLAN] = '{
        '{ROW_WORD, 7'd0,   32'sh8000_0000, 1'b0, 32'sh0},
        '{ROW_WORD, 7'd0,   32'sh7FFF_FFFF, 1'b0, 32'sh0},
        '{ROW_WORD, 7'd0,   32'sh0000_0000, 1'b1, 32'sh0},
        '{ROW_WORD, 7'd0,   32'shFFFF_FFFF, 1'b1, 32'sh0},
        '{ROW_WORD, 7'd0,   32'sh8000_0000, 1'b1, 32'shFFFF_FFFF},
        '{ROW_CFG,  7'd0,   32'sh0,         1'b0, 32'sh0},
        '{ROW_WORD, 7'd0,   32'sh7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF},
        '{ROW_WORD, 7'd0,   32'sh8000_0000, 1'b1, 32'sh8000_0000},
        '{ROW_WORD, 7'd0,   32'sh5555_5555, 1'b1, 32'sh5555_5555},
        '{ROW_WORD, 7'd0,   32'shAAAA_AAAA, 1'b1, 32'shAAAA_AAAA},
        '{ROW_CFG,  7'd2,   32'sh0,         1'b0, 32'sh0},
        '{ROW_WORD, 7'd0,   32'sh5,         1'b0, 32'sh0},
        '{ROW_WORD, 7'd0,   32'sh5,         1'b1, 32'sh5},
        '{ROW_WORD, 7'd0,   32'shFFFF_FFF9, 1'b1, 32'shFFFF_FFF9},
        '{ROW_CFG,  7'd3,   32'sh0,         1'b0, 32'sh0},
        '{ROW_WORD, 7'd0,   32'sh64,        1'b0, 32'sh0},
        '{ROW_CFG,  7'd4,   32'sh0,         1'b0, 32'sh0},
        '{ROW_WORD, 7'd0,   32'sh3,         1'b0, 32'sh0},
        '{ROW_WORD, 7'd0,   32'sh3,         1'b0, 32'sh0},
        '{ROW_WORD, 7'd0,   32'sh3,         1'b0, 32'sh0},
        '{ROW_WORD, 7'd0,   32'sh1,         1'b0, 32'sh0},
        '{ROW_WORD, 7'd0,   32'sh3,         1'b0, 32'sh0},
        '{ROW_WORD, 7'd0,   32'sh1,         1'b0, 32'sh0}
    };

    task automatic report_mismatch(input string msg);
        errors++;
        $display("MISMATCH at cycle %0d: %s", cycles, msg);
    endtask

    // Advances the window by one word; returns 1 with the lower median once the window is full.
    function automatic bit median_step(input t_sample s, output t_sample med);
        int      pos;
        t_sample oldest;
        med = '0;
        win_arrival.push_back(s);
        if (win_arrival.size() > win_size) begin
            oldest = win_arrival.pop_front();
            pos = 0;
            while (pos < win_sorted.size() && win_sorted[pos] != oldest) pos++;
            if (pos < win_sorted.size()) win_sorted.delete(pos);
        end
        pos = 0;
        while (pos < win_sorted.size() && win_sorted[pos] <= s) pos++;
        win_sorted.insert(pos, s);
        if (win_arrival.size() == win_size) begin
            med = win_sorted[(win_size + 1) / 2 - 1];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Mixes full-range words with small values, the extremes, and repeats or near neighbours of the last word.
    function automatic t_sample pick_word();
        t_sample s;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: s = t_sample'($urandom);
            4, 5, 6:    s = t_sample'($urandom_range(0, 8)) - t_sample'(4);
            7: begin
                case ($urandom_range(0, 3))
                    0:       s = 32'sh8000_0000;
                    1:       s = 32'sh7FFF_FFFF;
                    2:       s = '0;
                    default: s = 32'shFFFF_FFFF;
                endcase
            end
            8:       s = last_word;
            default: s = last_word + t_sample'($urandom_range(0, 6)) - t_sample'(3);
        endcase
        last_word = s;
        return s;
    endfunction

    // Offers one word with random gaps in front and books the median it should produce.
    task automatic send_word(input t_sample s, input logic typed, input t_sample typed_med);
        t_sample med;
        bit      has_med;
        while (!no_stall && $urandom_range(0, 99) < 36) begin
            smp_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_if.valid  <= 1'b1;
        smp_if.sample <= s;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        has_med = median_step(s, med);
        if (typed) median_q.push_back(typed_med);
        else if (has_med) median_q.push_back(med);
        words_sent++;
    endtask

    // The window size is only changed once every owed median is out and the pipe has drained.
    task automatic write_window(input t_cfg v);
        smp_if.valid <= 1'b0;
        while (median_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (v == '0) win_size = 1;
        else if (int'(v) > WINDOW_MAX) win_size = WINDOW_MAX;
        else win_size = int'(v);
        win_arrival.delete();
        win_sorted.delete();
        windows_set++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            med_if.ready <= 1'b0;
        end else begin
            med_if.ready <= no_stall || ($urandom_range(0, 99) >= 36);
        end
    end

    always @(posedge i_clk) begin
        t_sample want;
        if (i_rst_n && med_if.valid && med_if.ready) begin
            medians_seen++;
            if (median_q.size() == 0) begin
                report_mismatch($sformatf("median %0d with none owed", med_if.median));
            end else begin
                want = median_q.pop_front();
                if (med_if.median !== want) begin
                    report_mismatch($sformatf("median %0d, want %0d", med_if.median, want));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("sliding_window_median test failed");
            $finish;
        end
    end

    initial begin
        int rand_sent;
        int phase;
        int n;
        int k;
        t_cfg v;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        smp_if.valid  = 1'b0;
        smp_if.sample = '0;
        win_size      = WIN_RESET;
        last_word     = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) write_window(plan[r].cfg);
            else send_word(plan[r].word, plan[r].typed, plan[r].median);
        end

        // Random phases: setting 127 and size 64 first, both the largest window, then sizes one
        // and two, then a mix of mostly small windows; some phases stop before the window has filled.
        rand_sent = 0;
        phase = 0;
        while (rand_sent < RAND_WORDS) begin
            case (phase)
                0:       v = 7'd127;
                1:       v = 7'd64;
                2:       v = 7'd1;
                3:       v = 7'd2;
                default: v = ($urandom_range(0, 9) < 7) ? t_cfg'($urandom_range(0, 12))
                                                        : t_cfg'($urandom_range(0, 127));
            endcase
            write_window(v);
            if (phase >= 4 && $urandom_range(0, 3) == 0) n = $urandom_range(1, win_size);
            else n = win_size + $urandom_range(5, 40);
            for (k = 0; k < n && rand_sent < RAND_WORDS; k++) begin
                no_stall = (rand_sent >= 250 && rand_sent < 400);
                send_word(pick_word(), 1'b0, '0);
                rand_sent++;
            end
            phase++;
        end
        no_stall = 1'b0;
        smp_if.valid <= 1'b0;

        for (k = 0; k < 2000 && median_q.size() != 0; k++) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        while (median_q.size() != 0) begin
            report_mismatch($sformatf("median %0d never arrived", median_q.pop_front()));
        end

        $display("Run covered %0d words over %0d window size writes; %0d medians compared.",
                 words_sent, windows_set, medians_seen);
        $display("Mismatches: %0d", errors);
        if (errors == 0) begin
            $display("sliding_window_median test passed");
        end else begin
            $display("sliding_window_median test failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/swm_pkg.sv
sv/swm_sample_if.sv
sv/swm_median_if.sv
sv/swm_sorted_window.sv
sv/sliding_window_median.sv
bench/tb_top.sv
